/* rtl/core/asd_pkg.sv */
package asd_pkg;

   // Values of the decode mode register. Codes above MODE_ALAW behave as MODE_PASS.
   localparam logic [2:0] MODE_PASS  = 3'd0;
   localparam logic [2:0] MODE_FLIP  = 3'd1;
   localparam logic [2:0] MODE_SWAP  = 3'd2;
   localparam logic [2:0] MODE_MULAW = 3'd3;
   localparam logic [2:0] MODE_ALAW  = 3'd4;

   // What the back end still has to do with a queued word.
   localparam logic [1:0] OP_DIRECT = 2'd0;
   localparam logic [1:0] OP_MULAW  = 2'd1;
   localparam logic [1:0] OP_ALAW   = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] word;
      logic        wide;
      logic        last;
   } entry_type;

endpackage

/* rtl/core/asd_if.sv */
interface asd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface asd_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] out_word;
   logic        out_wide;
   logic        out_last;

   modport source (output valid, output out_word, output out_wide, output out_last,
                   input ready);
   modport sink (input valid, input out_word, input out_wide, input out_last,
                 output ready);
endinterface

/* rtl/core/audio_sample_decoder.sv */
// Audio sample decoder: one encoded audio byte per word on req_ch, at most one
// converted word per input byte on rsp_ch, both valid/ready channels.
// csr_we/csr_wdata write the decode mode: pass, signed-to-unsigned 8-bit, 16-bit
// byte swap, mu-law expand or A-law expand. Write it only while the block is idle;
// a write also drops a half-received byte pair.
// Throughput is one byte per cycle in every mode while the queue is not full. In swap mode the first byte
// of a pair produces no output and the second produces one 16-bit word.
// An accepted byte's result passes through the classify stage into the queue,
// then from the queue head through the expander into the output register.
// When the receiver stalls, the output register holds its word and the queue
// absorbs up to QUEUE_DEPTH more; req_ch.ready drops only when the queue is full.
// Synchronous reset clears the mode to pass-through, empties the queue and
// output register and forgets any held byte.
module audio_sample_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   asd_req_if.sink    req_ch,
   asd_rsp_if.source  rsp_ch,
   input  logic       csr_we,
   input  logic [2:0] csr_wdata
);
   import asd_pkg::*;

   // Classified words travel from the front end to the back end through a short
   // queue so that an output stall does not stop input acceptance at once.
   entry_type push_entry;
   entry_type head_entry;
   logic      q_push;
   logic      q_full;
   logic      q_valid;
   logic      q_pop;

   asd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (push_entry)
   );

   asd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .valid      (q_valid),
      .head       (head_entry)
   );

   // The back end expands G.711 codes and owns the output register.
   asd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_head  (head_entry),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

`ifndef SYNTHESIS
   // The front end must never write into a full queue.
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("queue push while full");

   // The back end must only take a word that is present.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("queue pop while empty");

   // Reset leaves no word in flight.
   assert property (@(posedge clock) reset |=> !q_valid && !rsp_ch.valid)
      else $error("word in flight after reset");
`endif

endmodule

/* rtl/core/asd_front.sv */
module asd_front (
   input  logic                clock,
   input  logic                reset,
   asd_req_if.sink             req_ch,
   input  logic                csr_we,
   input  logic [2:0]          csr_wdata,
   input  logic                q_full,
   output logic                q_push,
   output asd_pkg::entry_type  q_entry
);
   import asd_pkg::*;

   logic [2:0] mode_ff, mode_in;
   logic       pair_ff, pair_in;
   logic [7:0] held_ff, held_in;
   logic       accept;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && !q_full;

   always_comb begin
      mode_in      = mode_ff;
      pair_in      = pair_ff;
      held_in      = held_ff;
      q_push       = 1'b0;
      q_entry.op   = OP_DIRECT;
      q_entry.word = {8'h00, req_ch.in_byte};
      q_entry.wide = 1'b0;
      q_entry.last = req_ch.in_last;
      if (accept) begin
         q_push = 1'b1;
         case (mode_ff)
            MODE_FLIP: begin
               q_entry.word = {8'h00, req_ch.in_byte ^ 8'h80};
            end
            MODE_SWAP: begin
               q_entry.wide = 1'b1;
               q_entry.word = {held_ff, req_ch.in_byte};
               if (pair_ff) begin
                  pair_in = 1'b0;
               end else begin
                  // First byte of a pair is held; an odd closing byte is dropped.
                  q_push  = 1'b0;
                  pair_in = !req_ch.in_last;
                  held_in = req_ch.in_byte;
               end
            end
            MODE_MULAW: begin
               q_entry.op   = OP_MULAW;
               q_entry.wide = 1'b1;
            end
            MODE_ALAW: begin
               q_entry.op   = OP_ALAW;
               q_entry.wide = 1'b1;
            end
            default: begin
               q_entry.op = OP_DIRECT;
            end
         endcase
      end
      // A mode write always drops a half-built pair.
      if (csr_we) begin
         mode_in = csr_wdata;
         pair_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PASS;
         pair_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         pair_ff <= pair_in;
      end
      held_ff <= held_in;
   end

endmodule

/* rtl/core/asd_queue.sv */
module asd_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  asd_pkg::entry_type  push_entry,
   output logic                full,
   input  logic                pop,
   output logic                valid,
   output asd_pkg::entry_type  head
);
   import asd_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   entry_type        slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full  = (count_ff == CW'(DEPTH));
   assign valid = (count_ff != '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* rtl/core/asd_back.sv */
module asd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  asd_pkg::entry_type  q_head,
   output logic                q_pop,
   asd_rsp_if.source           rsp_ch
);
   import asd_pkg::*;

   localparam logic [15:0] MU_BASE [8] = '{
      16'd0, 16'd132, 16'd396, 16'd924, 16'd1980, 16'd4092, 16'd8316, 16'd16764
   };

   function automatic logic [15:0] expand_mu(input logic [7:0] b);
      logic [7:0]  c;
      logic [15:0] mag;
      c   = ~b;
      mag = MU_BASE[c[6:4]] + ({12'h000, c[3:0]} << ({1'b0, c[6:4]} + 4'd3));
      return c[7] ? (~mag + 16'd1) : mag;
   endfunction

   function automatic logic [15:0] expand_alaw(input logic [7:0] b);
      logic [7:0]  c;
      logic [15:0] t;
      c = b ^ 8'h55;
      t = {8'h00, c[3:0], 4'h0};
      if (c[6:4] == 3'd0) begin
         t = t + 16'h0008;
      end else begin
         t = (t + 16'h0108) << (c[6:4] - 3'd1);
      end
      return c[7] ? t : (~t + 16'd1);
   endfunction

   logic        valid_ff, valid_in;
   logic [15:0] word_ff, word_in;
   logic        wide_ff, last_ff;

   assign q_pop = q_valid && (!valid_ff || rsp_ch.ready);

   always_comb begin
      case (q_head.op)
         OP_MULAW: word_in = expand_mu(q_head.word[7:0]);
         OP_ALAW:  word_in = expand_alaw(q_head.word[7:0]);
         default:  word_in = q_head.word;
      endcase
      valid_in = valid_ff;
      if (q_pop) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (q_pop) begin
         word_ff <= word_in;
         wide_ff <= q_head.wide;
         last_ff <= q_head.last;
      end
   end

   assign rsp_ch.valid    = valid_ff;
   assign rsp_ch.out_word = word_ff;
   assign rsp_ch.out_wide = wide_ff;
   assign rsp_ch.out_last = last_ff;

endmodule
